// ----- rtl/ppsch_pkg.sv -----
// ---------------------------------------------------------------------------
// ppsch_pkg: shared types and constants of the priority scheduler
// Word formats, status codes and the candidate record passed along the cells.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ppsch_pkg;

  // Default table depth
  localparam int MAX_TASKS_DEF = 16;

  // Reset value of the task count register
  localparam logic [4:0] TASK_COUNT_RST = 5'd16;

  // Input kinds
  localparam logic KIND_ARRIVE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  // Result status codes
  localparam logic [1:0] STAT_STORED  = 2'd0;
  localparam logic [1:0] STAT_DROPPED = 2'd1;
  localparam logic [1:0] STAT_RAN     = 2'd2;
  localparam logic [1:0] STAT_IDLE    = 2'd3;

  // Input word
  typedef struct packed {
    logic        kind;
    logic [7:0]  task_id;
    logic [7:0]  priority_req;
    logic [15:0] burst;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  ran_task_id;
    logic        finished;
    logic [23:0] finish_time;
    logic [23:0] turnaround;
    logic [23:0] wait_span;
    logic [31:0] wait_total;
    logic        all_done;
  } out_word_t;

  // Write broadcast into the table
  typedef struct packed {
    logic        en;
    logic [7:0]  ident;
    logic [7:0]  prio;
    logic [15:0] burst;
    logic [23:0] arrival;
  } cell_wr_t;

  // Best task seen so far, handed from cell to cell
  typedef struct packed {
    logic        valid;
    logic [7:0]  prio;
    logic [23:0] arrival;
    logic [15:0] burst;
    logic [15:0] remaining;
    logic [7:0]  ident;
  } cand_t;

endpackage

`default_nettype wire

// ----- rtl/ppsch_cell.sv -----
// ---------------------------------------------------------------------------
// ppsch_cell: one task slot of the scheduler chain
// Holds one task and passes on the better of its own task and the incoming
// candidate, one cell per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppsch_cell
  import ppsch_pkg::*;
#(
  parameter int IDX_W = $clog2(MAX_TASKS_DEF)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [IDX_W-1:0] slot_id,
  input  wire cell_wr_t         wr,
  input  wire logic [IDX_W-1:0] wr_slot,
  input  wire logic             run_en,
  input  wire logic [IDX_W-1:0] run_slot,
  input  wire cand_t            cand_in,
  input  wire logic [IDX_W-1:0] slot_in,
  output cand_t                 cand_out,
  output logic [IDX_W-1:0]      slot_out
);

  logic             live_r;
  logic [7:0]       prio_r;
  logic [15:0]      rem_r;
  logic [15:0]      burst_r;
  logic [23:0]      arr_r;
  logic [7:0]       ident_r;
  cand_t            cand_r;
  cand_t            cand_nxt;
  logic [IDX_W-1:0] slot_r;
  logic [IDX_W-1:0] slot_nxt;
  logic [15:0]      rem_dec;
  logic             take_self;
  logic             wr_hit;
  logic             run_hit;

  assign wr_hit  = wr.en && (wr_slot == slot_id);
  assign run_hit = run_en && live_r && (run_slot == slot_id);
  assign rem_dec = (rem_r != 16'd0) ? rem_r - 16'd1 : 16'd0;

  // Pick own task over the incoming one: lower priority, then earlier arrival
  always_comb begin
    take_self = live_r &&
                (!cand_in.valid ||
                 (prio_r < cand_in.prio) ||
                 ((prio_r == cand_in.prio) && (arr_r < cand_in.arrival)));
    if (take_self) begin
      cand_nxt.valid     = 1'b1;
      cand_nxt.prio      = prio_r;
      cand_nxt.arrival   = arr_r;
      cand_nxt.burst     = burst_r;
      cand_nxt.remaining = rem_r;
      cand_nxt.ident     = ident_r;
      slot_nxt           = slot_id;
    end else begin
      cand_nxt = cand_in;
      slot_nxt = slot_in;
    end
  end

  // Slot occupancy: set on store, drop when the burst runs out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= 1'b0;
    end else if (wr_hit) begin
      live_r <= 1'b1;
    end else if (run_hit && (rem_dec == 16'd0)) begin
      live_r <= 1'b0;
    end
  end

  // Task fields
  always_ff @(posedge clk) begin
    if (wr_hit) begin
      prio_r  <= wr.prio;
      rem_r   <= wr.burst;
      burst_r <= wr.burst;
      arr_r   <= wr.arrival;
      ident_r <= wr.ident;
    end else if (run_hit) begin
      rem_r <= rem_dec;
    end
  end

  // Advance the candidate to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r <= '0;
    end else begin
      cand_r <= cand_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign cand_out = cand_r;
  assign slot_out = slot_r;

endmodule

`default_nettype wire

// ----- rtl/preemptive_priority_scheduler.sv -----
// ---------------------------------------------------------------------------
// preemptive_priority_scheduler: priority scheduler over a row of task cells
// Arrivals fill the next unused cell; a tick sweeps the cell chain for the
// best ready task, runs it one time unit and reports the outcome.
//
//   port group | direction | word        | handshake
//   in_        | input     | in_word_t   | in_valid / in_stall
//   out_       | output    | out_word_t  | out_valid / out_stall
//   cfg_       | input     | task_count  | cfg_we, no wait
//
// An arrival is answered in the cycle after it is taken. A tick is answered
// after the sweep: the best candidate moves one cell per cycle down the chain,
// then the commit state waits until the result register is free. The next
// word can be taken at the edge after the result appears, provided the result
// leaves then. Items are taken one at a time; a new word is taken once the
// result register is free or being drained. Synchronous reset empties the
// table and clears time, counters and the result valid flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module preemptive_priority_scheduler
  import ppsch_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_word_t   in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_word_t       out_data,
  input  wire logic       cfg_we,
  input  wire logic [4:0] cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state_r;
  logic [1:0]       state_nxt;
  logic [IDX_W-1:0] scan_cnt_r;
  logic [IDX_W-1:0] scan_cnt_nxt;
  logic [4:0]       task_count_r;
  logic [23:0]      time_r;
  logic [23:0]      time_nxt;
  logic [CNT_W-1:0] next_slot_r;
  logic [CNT_W-1:0] next_slot_nxt;
  logic [CNT_W-1:0] done_r;
  logic [CNT_W-1:0] done_nxt;
  logic [31:0]      wait_sum_r;
  logic [31:0]      wait_sum_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  out_word_t        out_word_r;
  out_word_t        out_word_nxt;

  cand_t            cand_link [MAX_TASKS+1];
  logic [IDX_W-1:0] slot_link [MAX_TASKS+1];
  cell_wr_t         cell_wr;
  logic             run_en;

  cand_t            win;
  logic             in_take;
  logic             out_free;
  logic             has_room;
  logic             commit;
  logic             fin;
  logic [23:0]      comp;
  logic [23:0]      tat;
  logic [23:0]      wt;
  logic [32:0]      sum_ext;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign in_take  = in_valid && !in_stall;
  assign has_room = next_slot_r < CNT_W'(MAX_TASKS);
  assign commit   = (state_r == ST_DONE) && out_free;

  // Cell chain: an empty candidate enters at the head
  assign cand_link[0] = '0;
  assign slot_link[0] = '0;

  assign cell_wr.en      = in_take && (in_data.kind == KIND_ARRIVE) && has_room;
  assign cell_wr.ident   = in_data.task_id;
  assign cell_wr.prio    = in_data.priority_req;
  assign cell_wr.burst   = in_data.burst;
  assign cell_wr.arrival = time_r;

  assign win    = cand_link[MAX_TASKS];
  assign run_en = commit && win.valid;

  for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
    ppsch_cell #(
      .IDX_W (IDX_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .slot_id  (IDX_W'(k)),
      .wr       (cell_wr),
      .wr_slot  (next_slot_r[IDX_W-1:0]),
      .run_en   (run_en),
      .run_slot (slot_link[MAX_TASKS]),
      .cand_in  (cand_link[k]),
      .slot_in  (slot_link[k]),
      .cand_out (cand_link[k+1]),
      .slot_out (slot_link[k+1])
    );
  end

  // Completion figures of the winning task
  always_comb begin
    fin     = win.valid && (win.remaining <= 16'd1);
    comp    = time_r + 24'd1;
    tat     = comp - win.arrival;
    wt      = (tat >= {8'd0, win.burst}) ? tat - {8'd0, win.burst} : 24'd0;
    sum_ext = {1'b0, wait_sum_r} + {9'd0, wt};
  end

  // Sequencer: idle, sweep the chain, commit the tick
  always_comb begin
    state_nxt    = state_r;
    scan_cnt_nxt = scan_cnt_r;
    case (state_r)
      ST_IDLE: begin
        scan_cnt_nxt = '0;
        if (in_take && (in_data.kind == KIND_TICK)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_cnt_nxt = scan_cnt_r + IDX_W'(1);
        if (scan_cnt_r == IDX_W'(MAX_TASKS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Time, counters and the result word
  always_comb begin
    time_nxt      = time_r;
    next_slot_nxt = next_slot_r;
    done_nxt      = done_r;
    wait_sum_nxt  = wait_sum_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;

    if (in_take && (in_data.kind == KIND_ARRIVE)) begin
      if (has_room) begin
        next_slot_nxt = next_slot_r + CNT_W'(1);
      end
    end
    if (commit) begin
      time_nxt = comp;
      if (fin) begin
        done_nxt     = done_r + CNT_W'(1);
        wait_sum_nxt = sum_ext[32] ? 32'hFFFF_FFFF : sum_ext[31:0];
      end
    end

    if ((in_take && (in_data.kind == KIND_ARRIVE)) || commit) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = '0;
      if (commit) begin
        if (win.valid) begin
          out_word_nxt.status      = STAT_RAN;
          out_word_nxt.ran_task_id = win.ident;
          if (fin) begin
            out_word_nxt.finished    = 1'b1;
            out_word_nxt.finish_time = comp;
            out_word_nxt.turnaround  = tat;
            out_word_nxt.wait_span   = wt;
          end
        end else begin
          out_word_nxt.status = STAT_IDLE;
        end
      end else begin
        out_word_nxt.status = has_room ? STAT_STORED : STAT_DROPPED;
      end
      out_word_nxt.wait_total = wait_sum_nxt;
      out_word_nxt.all_done   = CMP_W'(done_nxt) >= CMP_W'(task_count_r);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      scan_cnt_r   <= '0;
      task_count_r <= TASK_COUNT_RST;
      time_r       <= '0;
      next_slot_r  <= '0;
      done_r       <= '0;
      wait_sum_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      time_r      <= time_nxt;
      next_slot_r <= next_slot_nxt;
      done_r      <= done_nxt;
      wait_sum_r  <= wait_sum_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        task_count_r <= cfg_wdata;
      end
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

`default_nettype wire

// ----- bench/sched_monitor.sv -----
// ---------------------------------------------------------------------------
// sched_monitor: result predictor and comparator for the priority scheduler
// Watches the input, result and register ports, keeps its own copy of the
// task table, predicts one result word per accepted input word and compares
// every accepted result word against the oldest prediction still waiting.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sched_monitor
  import ppsch_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire in_word_t   in_data,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire out_word_t  out_data,
  input  wire logic       cfg_we,
  input  wire logic [4:0] cfg_wdata,
  output int              mismatches,
  output int              outstanding
);

  localparam int NUM_SLOTS = MAX_TASKS_DEF;

  // Shadow task table
  logic        slot_used   [NUM_SLOTS];
  logic [7:0]  slot_id     [NUM_SLOTS];
  logic [7:0]  slot_prio   [NUM_SLOTS];
  logic [15:0] slot_need   [NUM_SLOTS];
  logic [15:0] slot_left   [NUM_SLOTS];
  logic [23:0] slot_stamp  [NUM_SLOTS];

  logic [23:0] now;
  int          fill_ptr;
  int unsigned tasks_done;
  logic [31:0] wait_acc;
  logic [4:0]  done_goal;

  out_word_t   upcoming_reports[$];
  out_word_t   want;

  // Apply one input word to the shadow table and return the result word
  function automatic out_word_t schedule_item(input in_word_t w);
    out_word_t   r;
    int          pick;
    logic [23:0] comp;
    logic [23:0] tat;
    logic [23:0] wt;
    r = '0;
    if (w.kind == KIND_ARRIVE) begin
      if (fill_ptr < NUM_SLOTS) begin
        slot_used[fill_ptr]  = 1'b1;
        slot_id[fill_ptr]    = w.task_id;
        slot_prio[fill_ptr]  = w.priority_req;
        slot_need[fill_ptr]  = w.burst;
        slot_left[fill_ptr]  = w.burst;
        slot_stamp[fill_ptr] = now;
        fill_ptr++;
        r.status = STAT_STORED;
      end else begin
        r.status = STAT_DROPPED;
      end
    end else begin
      // Lowest priority number, then earliest arrival, then lowest slot
      pick = -1;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slot_used[i] && (pick < 0 || slot_prio[i] < slot_prio[pick] ||
            (slot_prio[i] == slot_prio[pick] && slot_stamp[i] < slot_stamp[pick])))
          pick = i;
      end
      if (pick < 0) begin
        r.status = STAT_IDLE;
      end else begin
        r.status      = STAT_RAN;
        r.ran_task_id = slot_id[pick];
        if (slot_left[pick] != 16'd0)
          slot_left[pick] = slot_left[pick] - 16'd1;
        if (slot_left[pick] == 16'd0) begin
          comp = now + 24'd1;
          tat  = comp - slot_stamp[pick];
          wt   = (tat >= {8'd0, slot_need[pick]}) ? tat - {8'd0, slot_need[pick]} : 24'd0;
          slot_used[pick] = 1'b0;
          if (tasks_done != 32'hFFFF_FFFF)
            tasks_done++;
          // Saturate the wait total
          if (wait_acc > 32'hFFFF_FFFF - {8'd0, wt})
            wait_acc = 32'hFFFF_FFFF;
          else
            wait_acc = wait_acc + {8'd0, wt};
          r.finished    = 1'b1;
          r.finish_time = comp;
          r.turnaround  = tat;
          r.wait_span   = wt;
        end
      end
      now = now + 24'd1;
    end
    r.wait_total = wait_acc;
    r.all_done   = (tasks_done >= 32'(done_goal));
    return r;
  endfunction

  // Compare results, then queue the prediction for a newly taken word
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_used[i]  = 1'b0;
        slot_id[i]    = '0;
        slot_prio[i]  = '0;
        slot_need[i]  = '0;
        slot_left[i]  = '0;
        slot_stamp[i] = '0;
      end
      now        = '0;
      fill_ptr   = 0;
      tasks_done = 0;
      wait_acc   = '0;
      done_goal  = TASK_COUNT_RST;
      upcoming_reports.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (upcoming_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("sched_monitor: unexpected result word %h at %0t", out_data, $realtime);
        end else begin
          want = upcoming_reports.pop_front();
          if (out_data !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"sched_monitor: mismatch at %0t\n",
                        "  expected st=%0d id=%0d fin=%0d ct=%0d ta=%0d wt=%0d tot=%0d done=%0d\n",
                        "  actual   st=%0d id=%0d fin=%0d ct=%0d ta=%0d wt=%0d tot=%0d done=%0d"},
                       $realtime,
                       want.status, want.ran_task_id, want.finished, want.finish_time,
                       want.turnaround, want.wait_span, want.wait_total, want.all_done,
                       out_data.status, out_data.ran_task_id, out_data.finished,
                       out_data.finish_time, out_data.turnaround, out_data.wait_span,
                       out_data.wait_total, out_data.all_done);
          end
        end
      end
      if (in_valid && !in_stall)
        upcoming_reports.push_back(schedule_item(in_data));
      if (cfg_we)
        done_goal = cfg_wdata;
    end
    outstanding = upcoming_reports.size();
  end

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

endmodule

// ----- bench/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench: stimulus and verdict for the priority scheduler
// Drives a directed run through idle ticks, preemption and tie breaks, then
// random arrivals and ticks under several task counts, with bursty input,
// random output stalls and one long output hold-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import ppsch_pkg::*;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_HALF} rx_mode_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_word_t   in_data;
  logic       out_valid;
  logic       out_stall;
  out_word_t  out_data;
  logic       cfg_we;
  logic [4:0] cfg_wdata;

  int mismatches;
  int outstanding;
  int results_seen = 0;
  int burst_left = 1;

  preemptive_priority_scheduler #(
    .MAX_TASKS (MAX_TASKS_DEF)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  sched_monitor u_monitor (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop if the run hangs
  initial begin
    #10_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  // Count result words taken
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      results_seen <= results_seen + 1;
  end

  // Stall the result side in random modes, with one long hold-off
  initial begin : receiver
    rx_mode_t mode;
    int       span;
    bit       held;
    held      = 1'b0;
    out_stall = 1'b0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(20, 120);
      repeat (span) begin
        @(negedge clk);
        if (!held && results_seen >= 100) begin
          held = 1'b1;
          out_stall <= 1'b1;
          repeat (600) @(negedge clk);
        end
        case (mode)
          RX_FREE:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 7) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:  out_stall <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // Offer one word, hold it until taken, then maybe open a gap
  task automatic offer_word(input in_word_t w);
    int gap;
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Mostly ticks; arrivals carry short bursts, long jobs sit at low urgency
  function automatic in_word_t random_word();
    in_word_t w;
    w.kind         = ($urandom_range(0, 9) == 0) ? KIND_ARRIVE : KIND_TICK;
    w.task_id      = 8'($urandom);
    w.priority_req = 8'($urandom);
    if ($urandom_range(0, 11) == 0) begin
      w.burst        = 16'($urandom_range(1, 65535));
      w.priority_req = w.priority_req | 8'hF0;
    end else begin
      w.burst = 16'($urandom_range(1, 6));
    end
    return w;
  endfunction

  task automatic arrive(input logic [7:0] id, input logic [7:0] prio,
                        input logic [15:0] need);
    in_word_t w;
    w.kind         = KIND_ARRIVE;
    w.task_id      = id;
    w.priority_req = prio;
    w.burst        = need;
    offer_word(w);
  endtask

  task automatic tick();
    in_word_t w;
    w      = random_word();
    w.kind = KIND_TICK;
    offer_word(w);
  endtask

  // Drain all results, then write the task count
  task automatic set_task_count(input logic [4:0] value);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input int count);
    repeat (count) offer_word(random_word());
  endtask

  initial begin : stimulus
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty table, field extremes, zero burst, preemption, ties
    tick();
    arrive(8'h00, 8'h00, 16'd1);
    arrive(8'hFF, 8'hFF, 16'hFFFF);
    arrive(8'hA5, 8'h5A, 16'd0);
    tick();
    tick();
    arrive(8'h11, 8'h40, 16'd2);
    tick();
    // More urgent arrival takes over the running task
    arrive(8'h22, 8'h10, 16'd1);
    tick();
    tick();
    arrive(8'h33, 8'h30, 16'd2);
    tick();
    // Same priority, later arrival waits
    arrive(8'h44, 8'h30, 16'd1);
    tick();
    tick();
    // Same priority and arrival time: lower slot first
    arrive(8'h55, 8'h30, 16'd1);
    arrive(8'h66, 8'h30, 16'd1);
    tick();
    tick();
    tick();

    // Random phases under several task counts
    set_task_count(5'd12);
    random_phase(160);
    set_task_count(5'd0);
    random_phase(160);
    set_task_count(5'd31);
    random_phase(160);
    set_task_count(5'd1);
    random_phase(160);
    set_task_count(5'd16);
    random_phase(160);

    // Wait out the remaining results and any stray output
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
